// File: hdl/tksc_pkg.sv
// ----------------------------------------------------------------------------
// tksc_pkg: shared types and constants for the TTL key slot cache
// Request opcodes, sequencer states and the words passed between the
// controller and the top level.
// ----------------------------------------------------------------------------
package tksc_pkg;

	localparam int KEY_W   = 64;
	localparam int SEC_W   = 256;
	localparam int TIME_W  = 32;
	localparam int OP_W    = 3;
	localparam int CNT_W   = 5;
	localparam int ENTRY_W = KEY_W + TIME_W;

	localparam logic [TIME_W-1:0] TTL_RESET = 32'd3600;

	// Request codes; 6 and 7 are unused and answer with a plain reject
	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 3'd0,
		OP_GET   = 3'd1,
		OP_HAS   = 3'd2,
		OP_EVICT = 3'd3,
		OP_CLEAR = 3'd4,
		OP_COUNT = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_READ,
		ST_RESP
	} state_t;

	// Captured request word
	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SEC_W-1:0]  secret;
		logic [TIME_W-1:0] now;
	} req_t;

	// Result summary from the controller; the secret comes from the RAM
	typedef struct packed {
		logic             ok;
		logic             get_hit;
		logic [CNT_W-1:0] live_count;
	} resp_t;

endpackage

// File: hdl/tksc_ram.sv
// ----------------------------------------------------------------------------
// tksc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tksc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/tksc_ctrl.sv
// ----------------------------------------------------------------------------
// tksc_ctrl: request sequencer for the TTL key slot cache
// Holds the slot valid bits, walks the key/expiry RAM one slot a cycle,
// records the first match and first free slot, then commits the request.
// ----------------------------------------------------------------------------
module tksc_ctrl import tksc_pkg::*; #(
	parameter int SLOTS = 16,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               in_valid,
	output logic               in_stall,
	input  req_t               req_in,
	input  logic [TIME_W-1:0]  ttl,
	// key/expiry RAM
	output logic               ent_re,
	output logic [SW-1:0]      ent_raddr,
	input  logic [ENTRY_W-1:0] ent_rdata,
	output logic [ENTRY_W-1:0] ent_wdata,
	// secret RAM
	output logic               sec_re,
	output logic [SW-1:0]      sec_raddr,
	output logic [SEC_W-1:0]   sec_wdata,
	// shared write port
	output logic               wr_en,
	output logic [SW-1:0]      wr_addr,
	// result side
	output logic               resp_valid,
	input  logic               resp_take,
	output resp_t              resp
);

	state_t              state_q, state_d;
	req_t                req_q;
	logic [CW-1:0]       iss_cnt_q;
	logic                rd_vld_s1;
	logic [SW-1:0]       rd_idx_s1;
	logic [SLOTS-1:0]    valid_q;
	logic [SLOTS-1:0]    exp_mask_q;
	logic                found_q, m_exp_q, free_found_q;
	logic [SW-1:0]       m_idx_q, f_idx_q;
	logic [CNT_W-1:0]    cnt_q;
	resp_t               resp_q;

	logic                accept, scan_done;
	logic                slot_v, slot_hit, slot_exp;
	logic [KEY_W-1:0]    slot_key;
	logic [TIME_W-1:0]   slot_expiry;
	logic                live_hit, key_nz, put_wr;
	logic [TIME_W:0]     exp_sum;
	logic [TIME_W-1:0]   exp_new;
	resp_t               resp_d;

	assign accept = in_valid && !in_stall;

	// slot under inspection: RAM data lines up with the _s1 index
	assign slot_key    = ent_rdata[ENTRY_W-1:TIME_W];
	assign slot_expiry = ent_rdata[TIME_W-1:0];
	assign slot_v      = valid_q[rd_idx_s1];
	assign slot_exp    = req_q.now >= slot_expiry;
	assign slot_hit    = rd_vld_s1 && slot_v && (slot_key == req_q.key);
	assign scan_done   = rd_vld_s1 && (rd_idx_s1 == SW'(SLOTS - 1));

	// commit decisions
	assign live_hit = found_q && !m_exp_q;
	assign key_nz   = req_q.key != '0;
	assign put_wr   = (state_q == ST_FIN) && (req_q.op == OP_PUT) && key_nz
		&& (live_hit || free_found_q);

	// saturating expiry
	assign exp_sum = {1'b0, req_q.now} + {1'b0, ttl};
	assign exp_new = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

	assign ent_raddr = iss_cnt_q[SW-1:0];
	assign ent_wdata = {req_q.key, exp_new};
	assign sec_wdata = req_q.secret;
	assign sec_raddr = m_idx_q;
	assign wr_en     = put_wr;
	assign wr_addr   = live_hit ? m_idx_q : f_idx_q;
	assign resp      = resp_q;

	// result summary formed at commit
	always_comb begin
		resp_d = '0;
		case (req_q.op)
			OP_PUT: begin
				resp_d.ok = key_nz && (live_hit || free_found_q);
			end
			OP_GET: begin
				resp_d.ok      = live_hit;
				resp_d.get_hit = live_hit;
			end
			OP_HAS: begin
				resp_d.ok = live_hit;
			end
			OP_EVICT, OP_CLEAR: begin
				resp_d.ok = 1'b1;
			end
			OP_COUNT: begin
				resp_d.ok         = 1'b1;
				resp_d.live_count = cnt_q;
			end
			default: begin
				resp_d = '0;
			end
		endcase
	end

	// next state and RAM strobes
	always_comb begin
		state_d    = state_q;
		in_stall   = state_q != ST_IDLE;
		ent_re     = 1'b0;
		sec_re     = 1'b0;
		resp_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				ent_re = iss_cnt_q < CW'(SLOTS);
				if (scan_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				sec_re  = (req_q.op == OP_GET) && live_hit;
				state_d = sec_re ? ST_READ : ST_RESP;
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				resp_valid = 1'b1;
				if (resp_take) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
		end
	end

	// scan bookkeeping, valid bits and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_cnt_q    <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			valid_q      <= '0;
			exp_mask_q   <= '0;
			found_q      <= 1'b0;
			m_exp_q      <= 1'b0;
			m_idx_q      <= '0;
			free_found_q <= 1'b0;
			f_idx_q      <= '0;
			cnt_q        <= '0;
			resp_q       <= '0;
		end else begin
			rd_vld_s1 <= ent_re;
			rd_idx_s1 <= iss_cnt_q[SW-1:0];
			if (accept) begin
				iss_cnt_q    <= '0;
				exp_mask_q   <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				cnt_q        <= '0;
			end
			if (ent_re) begin
				iss_cnt_q <= iss_cnt_q + CW'(1);
			end
			// per-slot inspection
			if (rd_vld_s1) begin
				exp_mask_q[rd_idx_s1] <= slot_v && slot_exp;
				if (slot_hit && !found_q) begin
					found_q <= 1'b1;
					m_idx_q <= rd_idx_s1;
					m_exp_q <= slot_exp;
				end
				if ((!slot_v || slot_exp) && !free_found_q) begin
					free_found_q <= 1'b1;
					f_idx_q      <= rd_idx_s1;
				end
				if (req_q.op == OP_EVICT && slot_hit) begin
					valid_q[rd_idx_s1] <= 1'b0;
				end
				if (req_q.op == OP_COUNT && slot_v) begin
					if (slot_exp) begin
						valid_q[rd_idx_s1] <= 1'b0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
			end
			// commit
			if (state_q == ST_FIN) begin
				resp_q <= resp_d;
				case (req_q.op)
					OP_PUT: begin
						// no live match: reap expired slots before taking one
						valid_q <= ((key_nz && !live_hit) ? (valid_q & ~exp_mask_q) : valid_q)
							| (put_wr ? (SLOTS'(1) << wr_addr) : '0);
					end
					OP_GET, OP_HAS: begin
						if (found_q && m_exp_q) begin
							valid_q[m_idx_q] <= 1'b0;
						end
					end
					OP_CLEAR: begin
						valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: hdl/ttl_key_slot_cache.sv
// ----------------------------------------------------------------------------
// ttl_key_slot_cache: fully associative key/secret cache with TTL expiry
// Slots keep a 64-bit key, a 256-bit secret and an expiry time in RAM;
// requests put, get, has, evict, clear and count are handled one at a time.
//
//   channel  signals                              direction
//   request  in_valid / in_stall + fields         in
//   result   out_valid / out_stall + fields       out
//   config   cfg_wr_en / cfg_wr_data (ttl)        in
//
// The result word appears after a scan of the slots, one slot a cycle, through
// the single key/expiry read port, a drain of the last read, the commit and the
// load of the result register, plus the secret read on a get hit. A new request
// is taken only once the previous one has gone to the result register and the
// controller is back in idle. The result register frees the controller, so
// the next request is taken while a result still waits; its own result then
// holds the input stalled until the first one leaves. Reset empties every
// slot at once via the valid bits and loads ttl with 3600; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module ttl_key_slot_cache import tksc_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [TIME_W-1:0]  cfg_wr_data,
	// request
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    req_type,
	input  logic [KEY_W-1:0]   principal_key,
	input  logic [63:0]        secret_w0,
	input  logic [63:0]        secret_w1,
	input  logic [63:0]        secret_w2,
	input  logic [63:0]        secret_w3,
	input  logic [TIME_W-1:0]  now_time,
	// result
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [63:0]        out_w0,
	output logic [63:0]        out_w1,
	output logic [63:0]        out_w2,
	output logic [63:0]        out_w3,
	output logic [CNT_W-1:0]   live_count
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [TIME_W-1:0]  ttl_q;
	req_t               req_in;
	logic               ent_re, sec_re, wr_en;
	logic [SW-1:0]      ent_raddr, sec_raddr, wr_addr;
	logic [ENTRY_W-1:0] ent_rdata, ent_wdata;
	logic [SEC_W-1:0]   sec_rdata, sec_wdata;
	logic               resp_valid, resp_take;
	resp_t              resp;
	logic               out_valid_q;
	logic               ok_q;
	logic [SEC_W-1:0]   out_sec_q;
	logic [CNT_W-1:0]   live_count_q;

	// ttl register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_wr_en) begin
			ttl_q <= cfg_wr_data;
		end
	end

	assign req_in = '{
		op:     op_t'(req_type),
		key:    principal_key,
		secret: {secret_w3, secret_w2, secret_w1, secret_w0},
		now:    now_time
	};

	tksc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_in     (req_in),
		.ttl        (ttl_q),
		.ent_re     (ent_re),
		.ent_raddr  (ent_raddr),
		.ent_rdata  (ent_rdata),
		.ent_wdata  (ent_wdata),
		.sec_re     (sec_re),
		.sec_raddr  (sec_raddr),
		.sec_wdata  (sec_wdata),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.resp_valid (resp_valid),
		.resp_take  (resp_take),
		.resp       (resp)
	);

	// key and expiry per slot
	tksc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ent_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// secret per slot
	tksc_ram #(.WIDTH(SEC_W), .DEPTH(SLOTS)) u_sec_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (sec_wdata),
		.re    (sec_re),
		.raddr (sec_raddr),
		.rdata (sec_rdata)
	);

	// result register
	assign resp_take = resp_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_take) begin
			ok_q         <= resp.ok;
			out_sec_q    <= resp.get_hit ? sec_rdata : '0;
			live_count_q <= resp.live_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign out_w0     = out_sec_q[63:0];
	assign out_w1     = out_sec_q[127:64];
	assign out_w2     = out_sec_q[191:128];
	assign out_w3     = out_sec_q[255:192];
	assign live_count = live_count_q;

endmodule

// File: hdl/tksc_chk.sv
// ----------------------------------------------------------------------------
// tksc_chk: port-level checks for the TTL key slot cache
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module tksc_chk import tksc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               ok,
	input logic [63:0]        out_w0,
	input logic [63:0]        out_w1,
	input logic [63:0]        out_w2,
	input logic [63:0]        out_w3,
	input logic [CNT_W-1:0]   live_count
);

	// one request in flight: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in flight");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(out_w0)
			&& $stable(out_w1) && $stable(out_w2) && $stable(out_w3)
			&& $stable(live_count))
		else $error("stalled result changed");

	// a live count only comes with a successful count, no secret
	a_count_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && live_count != '0 |-> ok && out_w0 == '0 && out_w1 == '0
			&& out_w2 == '0 && out_w3 == '0)
		else $error("live count on a word that is not a count");

	// secret data only on a get hit
	a_secret_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_w0 != '0 || out_w1 != '0 || out_w2 != '0 || out_w3 != '0)
			|-> ok && live_count == '0)
		else $error("secret data on a word that is not a get hit");

endmodule

bind ttl_key_slot_cache tksc_chk u_tksc_chk (.*);

// File: bench/tksc_answer_checker.sv
// ----------------------------------------------------------------------------
// tksc_answer_checker: result checker for the TTL key slot cache
// Watches the request, result and ttl write ports, keeps its own copy of the
// slot store, works out the answer to every accepted request word and
// compares each returned word with the oldest answer still owed.
// ----------------------------------------------------------------------------
module tksc_answer_checker import tksc_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TIME_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [OP_W-1:0]   req_type,
	input  logic [KEY_W-1:0]  principal_key,
	input  logic [63:0]       secret_w0,
	input  logic [63:0]       secret_w1,
	input  logic [63:0]       secret_w2,
	input  logic [63:0]       secret_w3,
	input  logic [TIME_W-1:0] now_time,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              ok,
	input  logic [63:0]       out_w0,
	input  logic [63:0]       out_w1,
	input  logic [63:0]       out_w2,
	input  logic [63:0]       out_w3,
	input  logic [CNT_W-1:0]  live_count,
	output int                fail_count,
	output int                answers_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             ok;
		logic [SEC_W-1:0] secret;
		logic [CNT_W-1:0] live_count;
	} answer_t;

	// Shadow of the slot store and the ttl register
	logic              slot_live   [SLOTS];
	logic [KEY_W-1:0]  slot_key    [SLOTS];
	logic [SEC_W-1:0]  slot_secret [SLOTS];
	logic [TIME_W-1:0] slot_expiry [SLOTS];
	logic [TIME_W-1:0] lifetime;
	answer_t           answers_due [$];

	function automatic void empty_slot(int i);
		slot_live[i]   = 1'b0;
		slot_key[i]    = '0;
		slot_secret[i] = '0;
		slot_expiry[i] = '0;
	endfunction

	// First live slot holding the key; a stale match is emptied and misses
	function automatic int match_live_slot(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_live[i] && slot_key[i] == key) begin
				if (now >= slot_expiry[i]) begin
					empty_slot(i);
					return -1;
				end
				return i;
			end
		end
		return -1;
	endfunction

	// Apply one request to the shadow store and return its answer
	function automatic answer_t predict_answer(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [SEC_W-1:0] secret, logic [TIME_W-1:0] now);
		answer_t         a;
		int              s;
		int              live;
		logic [TIME_W:0] sum;
		a    = '0;
		live = 0;
		case (op)
			OP_PUT: begin
				if (key != '0) begin
					s = match_live_slot(key, now);
					// no live match: reap stale slots, take the lowest free one
					if (s < 0) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (slot_live[i] && now >= slot_expiry[i])
								empty_slot(i);
							if (!slot_live[i] && s < 0)
								s = i;
						end
					end
					if (s >= 0) begin
						sum            = {1'b0, now} + {1'b0, lifetime};
						slot_live[s]   = 1'b1;
						slot_key[s]    = key;
						slot_secret[s] = secret;
						slot_expiry[s] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
						a.ok           = 1'b1;
					end
				end
			end
			OP_GET: begin
				s = match_live_slot(key, now);
				if (s >= 0) begin
					a.ok     = 1'b1;
					a.secret = slot_secret[s];
				end
			end
			OP_HAS: begin
				a.ok = (match_live_slot(key, now) >= 0);
			end
			OP_EVICT: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i] && slot_key[i] == key)
						empty_slot(i);
				a.ok = 1'b1;
			end
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					empty_slot(i);
				a.ok = 1'b1;
			end
			OP_COUNT: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_live[i]) begin
						if (now >= slot_expiry[i])
							empty_slot(i);
						else
							live++;
					end
				end
				a.ok         = 1'b1;
				a.live_count = CNT_W'(live);
			end
			default: ;
		endcase
		return a;
	endfunction

	// Results are compared before the new request is predicted
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		int      bad;
		if (!arst_n) begin
			lifetime = TTL_RESET;
			for (int i = 0; i < SLOTS; i++)
				empty_slot(i);
			answers_due.delete();
			fail_count   <= 0;
			answers_owed <= 0;
		end else begin
			bad = 0;
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$error("result word with no request outstanding");
					bad = 1;
				end else begin
					want = answers_due.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						bad++;
					end
					if (out_w0 !== want.secret[63:0]) begin
						$error("out_w0: expected %h, got %h", want.secret[63:0], out_w0);
						bad++;
					end
					if (out_w1 !== want.secret[127:64]) begin
						$error("out_w1: expected %h, got %h", want.secret[127:64], out_w1);
						bad++;
					end
					if (out_w2 !== want.secret[191:128]) begin
						$error("out_w2: expected %h, got %h", want.secret[191:128], out_w2);
						bad++;
					end
					if (out_w3 !== want.secret[255:192]) begin
						$error("out_w3: expected %h, got %h", want.secret[255:192], out_w3);
						bad++;
					end
					if (live_count !== want.live_count) begin
						$error("live_count: expected %0d, got %0d", want.live_count, live_count);
						bad++;
					end
				end
			end
			if (cfg_wr_en)
				lifetime = cfg_wr_data;
			if (in_valid && !in_stall)
				answers_due.push_back(predict_answer(req_type, principal_key,
					{secret_w3, secret_w2, secret_w1, secret_w0}, now_time));
			fail_count   <= fail_count + bad;
			answers_owed <= answers_due.size();
		end
	end

endmodule

// File: bench/tb_ttl_key_slot_cache.sv
// ----------------------------------------------------------------------------
// tb_ttl_key_slot_cache: regression bench for the TTL key slot cache
// A short directed run over the edge cases, then phases of random requests
// under several ttl settings, with random idling on both channels, a long
// result hold-off and a stretch with no idling. The checker does the
// comparing; this module drives the block and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ttl_key_slot_cache;
	timeunit 1ns;
	timeprecision 1ps;
	import tksc_pkg::*;

	localparam int SLOTS           = 16;
	localparam int CLK_HALF        = 6;
	localparam int KEY_POOL        = 20;
	localparam int PHASES          = 7;
	localparam int PHASE_ITEMS     = 205;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int IDLE_PCT        = 7;

	// unused request codes, answered with a plain reject
	localparam logic [OP_W-1:0]   OP_SPARE_LO  = 3'd6;
	localparam logic [OP_W-1:0]   OP_SPARE_HI  = 3'd7;
	localparam logic [TIME_W-1:0] TIME_MAX     = '1;
	localparam logic [KEY_W-1:0]  KEY_ALL_ONES = '1;

	// ttl per random phase; the fifth entry is replaced by a random value
	localparam logic [TIME_W-1:0] TTL_PLAN [PHASES] =
		'{32'd40, 32'd0, TIME_MAX, 32'd1, 32'd0, 32'd300, TTL_RESET};

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [SEC_W-1:0]  secret;
		logic [TIME_W-1:0] now;
	} request_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_wr_en     = 1'b0;
	logic [TIME_W-1:0] cfg_wr_data   = '0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   req_type      = '0;
	logic [KEY_W-1:0]  principal_key = '0;
	logic [63:0]       secret_w0     = '0;
	logic [63:0]       secret_w1     = '0;
	logic [63:0]       secret_w2     = '0;
	logic [63:0]       secret_w3     = '0;
	logic [TIME_W-1:0] now_time      = '0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic              ok;
	logic [63:0]       out_w0;
	logic [63:0]       out_w1;
	logic [63:0]       out_w2;
	logic [63:0]       out_w3;
	logic [CNT_W-1:0]  live_count;
	int                fail_count;
	int                answers_owed;

	bit                calm         = 1'b0;
	bit                hold_off_ask = 1'b0;
	logic [KEY_W-1:0]  key_pool [KEY_POOL];
	logic [TIME_W-1:0] clock_s;

	ttl_key_slot_cache #(.SLOTS(SLOTS)) dut (.*);

	tksc_answer_checker #(.SLOTS(SLOTS)) answer_check (.*);

	initial forever #CLK_HALF clk = ~clk;

	// Result side: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_ask) begin
				hold_off_ask = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else
				out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog: too long without any word moving ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [63:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [SEC_W-1:0] random_secret();
		return {random_word(), random_word(), random_word(), random_word()};
	endfunction

	function automatic request_t make_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [SEC_W-1:0] secret, logic [TIME_W-1:0] now);
		request_t r;
		r.op     = op;
		r.key    = key;
		r.secret = secret;
		r.now    = now;
		return r;
	endfunction

	// Mostly pool keys on a slowly moving clock, so puts, hits, expiry and a
	// full store all come up; some zero, random or near-wrap values as noise
	function automatic request_t draw_request();
		request_t r;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)      r.op = OP_PUT;
		else if (pick < 63) r.op = OP_GET;
		else if (pick < 78) r.op = OP_HAS;
		else if (pick < 85) r.op = OP_EVICT;
		else if (pick < 95) r.op = OP_COUNT;
		else if (pick < 97) r.op = OP_CLEAR;
		else                r.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
		pick = $urandom_range(0, 99);
		if (pick < 4)      r.key = '0;
		else if (pick < 9) r.key = random_word();
		else               r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
		r.secret = random_secret();
		clock_s  = clock_s + $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		if (pick < 3)      r.now = $urandom();
		else if (pick < 5) r.now = TIME_MAX - $urandom_range(0, 63);
		else               r.now = clock_s;
		return r;
	endfunction

	// Offer one request word, with an occasional gap, until it is taken
	task automatic offer(input request_t r);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_type      <= r.op;
		principal_key <= r.key;
		secret_w0     <= r.secret[63:0];
		secret_w1     <= r.secret[127:64];
		secret_w2     <= r.secret[191:128];
		secret_w3     <= r.secret[255:192];
		now_time      <= r.now;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering until every owed result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_owed != 0) @(posedge clk);
	endtask

	task automatic write_ttl(input logic [TIME_W-1:0] ttl);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ttl;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Edge cases under the reset ttl of 3600
	task automatic run_directed();
		logic [KEY_W-1:0] k;
		k = random_word() | 64'd1;
		offer(make_request(OP_COUNT, '0, '0, '0));                   // empty after reset
		offer(make_request(OP_PUT, '0, '1, 32'd5));                  // zero key rejected
		offer(make_request(OP_GET, '0, '0, 32'd5));
		offer(make_request(OP_PUT, k, '1, '0));
		offer(make_request(OP_GET, k, '0, 32'd3599));                // last live second
		offer(make_request(OP_HAS, k, '0, 32'd10));
		offer(make_request(OP_GET, k, '0, TTL_RESET));               // expired, cleared
		offer(make_request(OP_HAS, k, '0, 32'd10));                  // stays gone
		offer(make_request(OP_PUT, KEY_ALL_ONES, '0, TIME_MAX - 32'd16)); // expiry saturates
		offer(make_request(OP_GET, KEY_ALL_ONES, '0, TIME_MAX - 32'd1));
		offer(make_request(OP_PUT, KEY_ALL_ONES, random_secret(), TIME_MAX - 32'd1));
		offer(make_request(OP_GET, KEY_ALL_ONES, '0, '0));           // refreshed secret
		offer(make_request(OP_HAS, KEY_ALL_ONES, '0, TIME_MAX));     // now equals expiry
		offer(make_request(OP_PUT, 64'd1, random_secret(), 32'd100));
		offer(make_request(OP_PUT, k, random_secret(), 32'd100));
		offer(make_request(OP_COUNT, '0, '0, 32'd200));
		offer(make_request(OP_EVICT, '0, '0, 32'd200));              // zero key matches nothing
		offer(make_request(OP_EVICT, 64'd1, '0, 32'd200));
		offer(make_request(OP_SPARE_LO, k, '1, 32'd200));
		offer(make_request(OP_SPARE_HI, k, '1, 32'd200));
		offer(make_request(OP_GET, k, '0, 32'd200));
		offer(make_request(OP_CLEAR, '0, '0, 32'd200));
		offer(make_request(OP_COUNT, '0, '0, 32'd200));
	endtask

	// Stimulus and verdict
	initial begin
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = random_word() | 64'd1;
		clock_s = $urandom_range(0, 1000);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_ttl(p == 4 ? TIME_W'($urandom()) : TTL_PLAN[p]);
			calm = (p == 2);
			if (p == 5)
				hold_off_ask = 1'b1;
			repeat (PHASE_ITEMS) offer(draw_request());
		end
		calm = 1'b0;
		drain();
		repeat (SLOTS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
